// ===== rtl/core/mbzo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbzo_pkg: shared types and codes for the bilinear mesh Z offset block
// Field types of the request, response and register channels, the command
// and register index codes, and the fixed fraction and blend widths.
// ----------------------------------------------------------------------------
package mbzo_pkg;

   // Q16.16 millimeter positions and offsets.
   typedef logic signed [31:0] q16_type;
   // Unsigned Q4.24 reciprocal grid spacing.
   typedef logic [27:0] inv_type;
   // Grid point index as carried by a write beat.
   typedef logic [2:0] grid_idx_type;
   // Register index on the configuration channel.
   typedef logic [2:0] csr_idx_type;
   typedef logic [31:0] csr_data_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam csr_idx_type CSR_ORIGIN_X      = 3'd0;
   localparam csr_idx_type CSR_ORIGIN_Y      = 3'd1;
   localparam csr_idx_type CSR_INV_SPACING_X = 3'd2;
   localparam csr_idx_type CSR_INV_SPACING_Y = 3'd3;
   localparam csr_idx_type CSR_EXTRAPOLATE   = 3'd4;

   localparam inv_type INV_SPACING_RESET = 28'h100_0000;

   // Cell fraction is Q.16 saturated to 28 bits; blended edges are 34 bits.
   localparam int FRAC_W = 28;
   localparam int MID_W  = 34;

endpackage
`default_nettype wire

// ===== rtl/core/mesh_bilinear_z_offset.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_bilinear_z_offset: bilinear Z offset lookup over a stored grid
// Holds a grid of Z offsets and blends the four corners around a queried
// XY position, with clamping at the grid edges and an extrapolation option.
// ----------------------------------------------------------------------------
// Usage
//   Request beats (req_valid / req_stall) carry either a grid point write
//   (req_cmd = write, req_grid_ix, req_grid_iy, req_point_value) or a query
//   (req_cmd = query, req_pos_x, req_pos_y). A write produces no response; a
//   query produces one response beat on rsp_valid / rsp_z_offset, in order.
//   The csr_ channel writes origin, reciprocal spacing and the extrapolation
//   flag; csr_ready is always high. Registers must be changed only while
//   the block is idle; the block does not enforce this. A grid point must
//   be written before a query reads it. A query passes eight register
//   stages: offset, scale multiply, cell clamp, grid read, Y blend,
//   edge clamp, X blend, output clamp. One beat is accepted every cycle
//   while req_stall is low; the two grid copies give four reads per cycle.
//   Reset clears the stage valid bits and loads the register defaults; grid
//   contents are unknown until written. When rsp_stall is high the response
//   holds, empty stages keep filling, and req_stall rises only once every
//   stage is full.
// ----------------------------------------------------------------------------
module mesh_bilinear_z_offset #(
   parameter int GRID_POINTS_X = 8,
   parameter int GRID_POINTS_Y = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   // Request channel
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        req_cmd,
   input  mbzo_pkg::q16_type          req_pos_x,
   input  mbzo_pkg::q16_type          req_pos_y,
   input  mbzo_pkg::grid_idx_type     req_grid_ix,
   input  mbzo_pkg::grid_idx_type     req_grid_iy,
   input  mbzo_pkg::q16_type          req_point_value,
   // Response channel
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output mbzo_pkg::q16_type          rsp_z_offset,
   // Configuration channel
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  mbzo_pkg::csr_idx_type      csr_index,
   input  mbzo_pkg::csr_data_type     csr_data
);
   import mbzo_pkg::*;

   localparam int PMAX   = (GRID_POINTS_X > GRID_POINTS_Y) ? GRID_POINTS_X : GRID_POINTS_Y;
   localparam int IDX_W  = $clog2(PMAX);
   localparam int IX_W   = $clog2(GRID_POINTS_X);
   localparam int IY_W   = $clog2(GRID_POINTS_Y);
   localparam int DEPTH  = GRID_POINTS_X * GRID_POINTS_Y;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic [IDX_W-1:0]         nxt;
      logic signed [FRAC_W-1:0] frac;
   } axis_type;

   // Cell index, next index and fraction for one axis from the scaled offset.
   function automatic axis_type axis_calc(input logic signed [61:0] ratio,
                                          input int points,
                                          input logic extrap);
      logic signed [21:0] g_raw;
      logic signed [21:0] g_hi;
      logic signed [21:0] g_c;
      logic signed [38:0] f;
      axis_type           r;
      g_raw = signed'(ratio[61:40]);
      g_hi  = extrap ? 22'(points - 2) : 22'(points - 1);
      if (g_raw < 22'sd0) begin
         g_c = '0;
      end else if (g_raw > g_hi) begin
         g_c = g_hi;
      end else begin
         g_c = g_raw;
      end
      f = 39'(signed'(ratio[61:24])) - 39'(signed'({g_c, 16'h0000}));
      if (!extrap && f < 39'sd0) begin
         f = '0;
      end
      if (f[38:27] == {12{f[38]}}) begin
         r.frac = f[27:0];
      end else begin
         r.frac = {f[38], {27{~f[38]}}};
      end
      r.idx = IDX_W'(g_c);
      if (g_c < 22'(points - 1)) begin
         r.nxt = IDX_W'(g_c + 22'sd1);
      end else begin
         r.nxt = IDX_W'(g_c);
      end
      return r;
   endfunction

   // Configuration registers
   q16_type origin_x_ff;
   q16_type origin_y_ff;
   inv_type inv_spacing_x_ff;
   inv_type inv_spacing_y_ff;
   logic    extrapolate_ff;

   // Stage valid bits and load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8;
   logic v4_in;

   // Stage 1: offsets from the origin
   logic signed [32:0] rel_x_in, rel_y_in;
   logic signed [32:0] rel_x1_ff, rel_y1_ff;
   logic               cmd1_ff;
   grid_idx_type       ix1_ff, iy1_ff;
   q16_type            pv1_ff;

   // Stage 2: scaled offsets in cells, Q.40
   logic signed [28:0] inv_x_s, inv_y_s;
   logic signed [61:0] ratio_x_in, ratio_y_in;
   logic signed [61:0] ratio_x2_ff, ratio_y2_ff;
   logic               cmd2_ff;
   grid_idx_type       ix2_ff, iy2_ff;
   q16_type            pv2_ff;

   // Stage 3: clamped cell indices and fractions
   axis_type              ax_x, ax_y;
   logic [IX_W-1:0]       gx3_ff, nx3_ff;
   logic [IY_W-1:0]       gy3_ff, ny3_ff;
   logic signed [FRAC_W-1:0] fx3_ff, fy3_ff;
   logic                  cmd3_ff;
   grid_idx_type          ix3_ff, iy3_ff;
   q16_type               pv3_ff;

   // Grid storage, two copies with two read ports each
   q16_type           mesh_a_ff [DEPTH];
   q16_type           mesh_b_ff [DEPTH];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] addr_00, addr_01, addr_10, addr_11;

   // Stage 4: corner heights
   q16_type                  z00_ff, z01_ff, z10_ff, z11_ff;
   logic signed [FRAC_W-1:0] fx4_ff, fy4_ff;

   // Stage 5: Y blend products
   logic signed [32:0]       diff_l, diff_r;
   logic signed [60:0]       prod_l_in, prod_r_in;
   logic signed [60:0]       prod_l5_ff, prod_r5_ff;
   q16_type                  z00_5_ff, z10_5_ff;
   logic signed [FRAC_W-1:0] fx5_ff;

   // Stage 6: saturated left and right edge heights
   logic signed [45:0]       l_sum, r_sum;
   logic signed [MID_W-1:0]  l_in, r_in;
   logic signed [MID_W-1:0]  l6_ff, r6_ff;
   logic signed [FRAC_W-1:0] fx6_ff;

   // Stage 7: X blend product
   logic signed [34:0]      diff_x;
   logic signed [62:0]      prod_x_in;
   logic signed [62:0]      prod7_ff;
   logic signed [MID_W-1:0] l7_ff;

   // Stage 8: saturated result
   logic signed [47:0] out_sum;
   q16_type            z_in;
   q16_type            z8_ff;

   // A stage loads when it is empty or the stage after it moves on.
   always_comb begin
      ld8 = !v8_ff || !rsp_stall;
      ld7 = !v7_ff || ld8;
      ld6 = !v6_ff || ld7;
      ld5 = !v5_ff || ld6;
      ld4 = !v4_ff || ld5;
      ld3 = !v3_ff || ld4;
      ld2 = !v2_ff || ld3;
      ld1 = !v1_ff || ld2;
   end

   assign req_stall    = !ld1;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = v8_ff;
   assign rsp_z_offset = z8_ff;

   // Writes leave the pipeline once they have updated the grid.
   assign v4_in = v3_ff && (cmd3_ff == CMD_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         inv_spacing_x_ff <= INV_SPACING_RESET;
         inv_spacing_y_ff <= INV_SPACING_RESET;
         extrapolate_ff   <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:      origin_x_ff      <= csr_data;
               CSR_ORIGIN_Y:      origin_y_ff      <= csr_data;
               CSR_INV_SPACING_X: inv_spacing_x_ff <= csr_data[27:0];
               CSR_INV_SPACING_Y: inv_spacing_y_ff <= csr_data[27:0];
               CSR_EXTRAPOLATE:   extrapolate_ff   <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (ld1) v1_ff <= req_valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v4_in;
         if (ld5) v5_ff <= v4_ff;
         if (ld6) v6_ff <= v5_ff;
         if (ld7) v7_ff <= v6_ff;
         if (ld8) v8_ff <= v7_ff;
      end
   end

   // Stage 1
   assign rel_x_in = 33'(req_pos_x) - 33'(origin_x_ff);
   assign rel_y_in = 33'(req_pos_y) - 33'(origin_y_ff);

   always_ff @(posedge clock) begin
      if (ld1) begin
         rel_x1_ff <= rel_x_in;
         rel_y1_ff <= rel_y_in;
         cmd1_ff   <= req_cmd;
         ix1_ff    <= req_grid_ix;
         iy1_ff    <= req_grid_iy;
         pv1_ff    <= req_point_value;
      end
   end

   // Stage 2
   assign inv_x_s    = signed'({1'b0, inv_spacing_x_ff});
   assign inv_y_s    = signed'({1'b0, inv_spacing_y_ff});
   assign ratio_x_in = rel_x1_ff * inv_x_s;
   assign ratio_y_in = rel_y1_ff * inv_y_s;

   always_ff @(posedge clock) begin
      if (ld2) begin
         ratio_x2_ff <= ratio_x_in;
         ratio_y2_ff <= ratio_y_in;
         cmd2_ff     <= cmd1_ff;
         ix2_ff      <= ix1_ff;
         iy2_ff      <= iy1_ff;
         pv2_ff      <= pv1_ff;
      end
   end

   // Stage 3
   always_comb begin
      ax_x = axis_calc(ratio_x2_ff, GRID_POINTS_X, extrapolate_ff);
      ax_y = axis_calc(ratio_y2_ff, GRID_POINTS_Y, extrapolate_ff);
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         gx3_ff  <= IX_W'(ax_x.idx);
         nx3_ff  <= IX_W'(ax_x.nxt);
         fx3_ff  <= ax_x.frac;
         gy3_ff  <= IY_W'(ax_y.idx);
         ny3_ff  <= IY_W'(ax_y.nxt);
         fy3_ff  <= ax_y.frac;
         cmd3_ff <= cmd2_ff;
         ix3_ff  <= ix2_ff;
         iy3_ff  <= iy2_ff;
         pv3_ff  <= pv2_ff;
      end
   end

   // Stage 4: grid write and corner reads. Both happen at the same stage, so
   // every query sees exactly the writes accepted before it.
   always_comb begin
      wr_en   = ld4 && v3_ff && (cmd3_ff == CMD_WRITE)
                && (int'(ix3_ff) < GRID_POINTS_X) && (int'(iy3_ff) < GRID_POINTS_Y);
      wr_addr = ADDR_W'(int'(iy3_ff) * GRID_POINTS_X + int'(ix3_ff));
      addr_00 = ADDR_W'(int'(gy3_ff) * GRID_POINTS_X + int'(gx3_ff));
      addr_01 = ADDR_W'(int'(ny3_ff) * GRID_POINTS_X + int'(gx3_ff));
      addr_10 = ADDR_W'(int'(gy3_ff) * GRID_POINTS_X + int'(nx3_ff));
      addr_11 = ADDR_W'(int'(ny3_ff) * GRID_POINTS_X + int'(nx3_ff));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mesh_a_ff[wr_addr] <= pv3_ff;
      end
      if (ld4) begin
         z00_ff <= mesh_a_ff[addr_00];
         z01_ff <= mesh_a_ff[addr_01];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mesh_b_ff[wr_addr] <= pv3_ff;
      end
      if (ld4) begin
         z10_ff <= mesh_b_ff[addr_10];
         z11_ff <= mesh_b_ff[addr_11];
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         fx4_ff <= fx3_ff;
         fy4_ff <= fy3_ff;
      end
   end

   // Stage 5
   assign diff_l    = 33'(z01_ff) - 33'(z00_ff);
   assign diff_r    = 33'(z11_ff) - 33'(z10_ff);
   assign prod_l_in = diff_l * fy4_ff;
   assign prod_r_in = diff_r * fy4_ff;

   always_ff @(posedge clock) begin
      if (ld5) begin
         prod_l5_ff <= prod_l_in;
         prod_r5_ff <= prod_r_in;
         z00_5_ff   <= z00_ff;
         z10_5_ff   <= z10_ff;
         fx5_ff     <= fx4_ff;
      end
   end

   // Stage 6: the shift by 16 is a floor, taken as the upper product bits.
   always_comb begin
      l_sum = 46'(z00_5_ff) + 46'(signed'(prod_l5_ff[60:16]));
      r_sum = 46'(z10_5_ff) + 46'(signed'(prod_r5_ff[60:16]));
      if (l_sum[45:33] == {13{l_sum[45]}}) begin
         l_in = l_sum[33:0];
      end else begin
         l_in = {l_sum[45], {33{~l_sum[45]}}};
      end
      if (r_sum[45:33] == {13{r_sum[45]}}) begin
         r_in = r_sum[33:0];
      end else begin
         r_in = {r_sum[45], {33{~r_sum[45]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ld6) begin
         l6_ff  <= l_in;
         r6_ff  <= r_in;
         fx6_ff <= fx5_ff;
      end
   end

   // Stage 7
   assign diff_x    = 35'(r6_ff) - 35'(l6_ff);
   assign prod_x_in = diff_x * fx6_ff;

   always_ff @(posedge clock) begin
      if (ld7) begin
         prod7_ff <= prod_x_in;
         l7_ff    <= l6_ff;
      end
   end

   // Stage 8
   always_comb begin
      out_sum = 48'(l7_ff) + 48'(signed'(prod7_ff[62:16]));
      if (out_sum[47:31] == {17{out_sum[47]}}) begin
         z_in = out_sum[31:0];
      end else begin
         z_in = {out_sum[47], {31{~out_sum[47]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ld8) begin
         z8_ff <= z_in;
      end
   end

`ifndef ASSERT_OFF
   // The next X index is the following column, or the last column itself.
   a_next_x: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (int'(nx3_ff) < GRID_POINTS_X)
                && ((int'(nx3_ff) == int'(gx3_ff) + 1)
                    || ((nx3_ff == gx3_ff) && (int'(gx3_ff) == GRID_POINTS_X - 1))))
      else $error("X corner indices out of step");

   // The next Y index is the following row, or the last row itself.
   a_next_y: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (int'(ny3_ff) < GRID_POINTS_Y)
                && ((int'(ny3_ff) == int'(gy3_ff) + 1)
                    || ((ny3_ff == gy3_ff) && (int'(gy3_ff) == GRID_POINTS_Y - 1))))
      else $error("Y corner indices out of step");

   // Corner heights held in a blocked stage must not be reread.
   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !ld5) |=> (v4_ff && $stable(z00_ff) && $stable(z01_ff)
                           && $stable(z10_ff) && $stable(z11_ff)))
      else $error("Grid read data changed while stalled");

   // Requests are held off only when no stage has room left.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff && v7_ff
                     && v8_ff && rsp_stall))
      else $error("Request stalled with an empty stage");
`endif

endmodule
`default_nettype wire

// ===== tb/mesh_bilinear_z_offset_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_bilinear_z_offset_tb: self-checking bench for the bilinear mesh lookup
// Loads the whole grid, then sends directed and random writes and queries
// under several register settings. Sender gaps and receiver stalls are random.
// Every query beat is scored against a cycle-free interpolation model.
// ----------------------------------------------------------------------------
module mesh_bilinear_z_offset_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbzo_pkg::*;

   localparam int GRID_X = 8;
   localparam int GRID_Y = 8;
   localparam int MM = 65536;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS = 300;
   localparam int PRINT_LIMIT = 40;
   localparam q16_type Q16_MAX = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN = 32'sh8000_0000;
   localparam inv_type INV_MAX = 28'hFFF_FFFF;
   localparam longint FRAC_HI = (longint'(1) << (FRAC_W - 1)) - 1;
   localparam longint FRAC_LO = -(longint'(1) << (FRAC_W - 1));
   localparam longint MID_HI = (longint'(1) << (MID_W - 1)) - 1;
   localparam longint MID_LO = -(longint'(1) << (MID_W - 1));

   typedef struct packed {
      logic         cmd;
      q16_type      pos_x;
      q16_type      pos_y;
      grid_idx_type ix;
      grid_idx_type iy;
      q16_type      value;
   } mesh_req_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic         req_cmd = CMD_WRITE;
   q16_type      req_pos_x = '0;
   q16_type      req_pos_y = '0;
   grid_idx_type req_grid_ix = '0;
   grid_idx_type req_grid_iy = '0;
   q16_type      req_point_value = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   q16_type      rsp_z_offset;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   csr_idx_type  csr_index = CSR_ORIGIN_X;
   csr_data_type csr_data = '0;

   mesh_req_type req_backlog[$];
   q16_type      z_expected[$];
   q16_type      mesh_shadow [GRID_Y][GRID_X];

   // Register shadows, loaded with the reset values.
   q16_type org_x_cfg = '0;
   q16_type org_y_cfg = '0;
   inv_type inv_x_cfg = INV_SPACING_RESET;
   inv_type inv_y_cfg = INV_SPACING_RESET;
   logic    extrap_cfg = 1'b0;

   int   error_count = 0;
   int   tx_gap = 0;
   int   stall_left = 0;
   bit   tx_calm = 1'b0;
   bit   rx_calm = 1'b0;
   logic hold_off = 1'b0;
   bit   stress_go = 1'b0;

   mesh_bilinear_z_offset #(
      .GRID_POINTS_X(GRID_X),
      .GRID_POINTS_Y(GRID_Y)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_grid_ix(req_grid_ix),
      .req_grid_iy(req_grid_iy),
      .req_point_value(req_point_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_z_offset(rsp_z_offset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("mesh_bilinear_z_offset_tb: errors");
      $finish;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Cell index along one axis; also gives the next index and the Q.16 fraction.
   function automatic longint locate_cell(q16_type pos, q16_type org, inv_type inv,
                                          int points, output longint nxt,
                                          output longint frac);
      longint ratio, g, f, top;
      ratio = (longint'(pos) - longint'(org)) * longint'(inv);
      g = ratio >>> 40;
      top = extrap_cfg ? points - 2 : points - 1;
      g = clip(g, 0, top);
      f = (ratio >>> 24) - g * 65536;
      if (!extrap_cfg && f < 0) begin
         f = 0;
      end
      frac = clip(f, FRAC_LO, FRAC_HI);
      nxt = (g + 1 < points - 1) ? g + 1 : points - 1;
      return g;
   endfunction

   function automatic q16_type interpolate_z(q16_type px, q16_type py);
      longint gx, gy, nx, ny, fx, fy, z00, z01, z10, z11, left, right, blend;
      gx = locate_cell(px, org_x_cfg, inv_x_cfg, GRID_X, nx, fx);
      gy = locate_cell(py, org_y_cfg, inv_y_cfg, GRID_Y, ny, fy);
      z00 = mesh_shadow[gy][gx];
      z01 = mesh_shadow[ny][gx];
      z10 = mesh_shadow[gy][nx];
      z11 = mesh_shadow[ny][nx];
      left = clip(z00 + (((z01 - z00) * fy) >>> 16), MID_LO, MID_HI);
      right = clip(z10 + (((z11 - z10) * fy) >>> 16), MID_LO, MID_HI);
      blend = left + (((right - left) * fx) >>> 16);
      return q16_type'(clip(blend, longint'(Q16_MIN), longint'(Q16_MAX)));
   endfunction

   function automatic void queue_write(int ix, int iy, q16_type v);
      mesh_req_type b;
      b.cmd = CMD_WRITE;
      b.pos_x = $urandom;
      b.pos_y = $urandom;
      b.ix = grid_idx_type'(ix);
      b.iy = grid_idx_type'(iy);
      b.value = v;
      req_backlog.push_back(b);
   endfunction

   function automatic void queue_query(q16_type x, q16_type y);
      mesh_req_type b;
      b.cmd = CMD_QUERY;
      b.pos_x = x;
      b.pos_y = y;
      b.ix = grid_idx_type'($urandom);
      b.iy = grid_idx_type'($urandom);
      b.value = $urandom;
      req_backlog.push_back(b);
   endfunction

   function automatic q16_type draw_height();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? Q16_MAX : Q16_MIN;
         1, 2: return q16_type'($urandom);
         default: return q16_type'(int'($urandom_range(0, 8 * MM)) - 4 * MM);
      endcase
   endfunction

   // Mostly positions over the grid and a little beyond, sometimes anywhere.
   function automatic q16_type draw_coord(q16_type org, inv_type inv, int points);
      longint span, off;
      if (inv == 0) begin
         span = longint'(1) << 20;
      end else begin
         span = (longint'(points - 1) << 40) / longint'(inv);
      end
      case ($urandom_range(0, 9))
         0, 1: return q16_type'($urandom);
         2: begin
            off = (inv == 0) ? 0 :
               (longint'($urandom_range(0, points - 1)) << 40) / longint'(inv);
         end
         default: begin
            off = longint'({$urandom, $urandom} % (span + span / 4 + 1)) - span / 8;
         end
      endcase
      return q16_type'(longint'(org) + off);
   endfunction

   function automatic csr_data_type draw_origin();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return Q16_MIN;
         2: return Q16_MAX;
         3: return $urandom;
         default: return csr_data_type'(int'($urandom_range(0, 64 * MM)) - 32 * MM);
      endcase
   endfunction

   // The upper nibble is junk that the block must drop.
   function automatic csr_data_type draw_inv();
      inv_type inv;
      case ($urandom_range(0, 7))
         0: inv = '0;
         1: inv = INV_MAX;
         2: inv = inv_type'($urandom);
         default: inv = inv_type'($urandom_range(1 << 20, 1 << 26));
      endcase
      return {4'($urandom), inv};
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("%0t ns: %s", $realtime, msg);
      end
   endtask

   task automatic write_reg(csr_idx_type idx, csr_data_type val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ORIGIN_X: org_x_cfg = val;
         CSR_ORIGIN_Y: org_y_cfg = val;
         CSR_INV_SPACING_X: inv_x_cfg = val[27:0];
         CSR_INV_SPACING_Y: inv_y_cfg = val[27:0];
         CSR_EXTRAPOLATE: extrap_cfg = val[0];
         default: ;
      endcase
   endtask

   // Sampled on the falling edge so the driver and scoreboard have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || z_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : req_side
      mesh_req_type b;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (tx_gap != 0) begin
            req_valid <= 1'b0;
            tx_gap <= tx_gap - 1;
         end else if (req_backlog.size() != 0) begin
            b = req_backlog.pop_front();
            req_cmd <= b.cmd;
            req_pos_x <= b.pos_x;
            req_pos_y <= b.pos_y;
            req_grid_ix <= b.ix;
            req_grid_iy <= b.iy;
            req_point_value <= b.value;
            req_valid <= 1'b1;
            if ($urandom_range(0, 47) == 0) begin
               tx_calm = !tx_calm;
            end
            // Back to back while the receiver is held off, so the pipe fills.
            tx_gap <= (tx_calm || hold_off) ? 0 : $urandom_range(0, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 47) == 0) begin
            rx_calm = !rx_calm;
         end
         n = rx_calm ? 0 : $urandom_range(0, 12);
         rsp_stall <= (n != 0);
         stall_left <= (n == 0) ? 0 : n - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : scoreboard
      q16_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (z_expected.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing pending, z_offset=%0d",
                                         rsp_z_offset));
            end else begin
               want = z_expected.pop_front();
               if (rsp_z_offset !== want) begin
                  report_mismatch($sformatf("z_offset %0d, expected %0d",
                                            rsp_z_offset, want));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_WRITE) begin
               mesh_shadow[req_grid_iy][req_grid_ix] = req_point_value;
            end else begin
               z_expected.push_back(interpolate_z(req_pos_x, req_pos_y));
            end
         end
      end
   end

   // Long receiver hold-offs while the sender keeps offering beats.
   initial begin
      wait (stress_go);
      repeat (2) begin
         repeat (400) @(posedge clock);
         hold_off <= 1'b1;
         repeat (100) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every grid point is written before anything can read it.
      for (int iy = 0; iy < GRID_Y; iy++) begin
         for (int ix = 0; ix < GRID_X; ix++) begin
            queue_write(ix, iy, draw_height());
         end
      end

      // Reset settings: one cell per millimeter, edges held.
      queue_write(7, 7, Q16_MIN);
      queue_write(6, 7, Q16_MAX);
      queue_write(0, 0, Q16_MAX);
      queue_query(0, 0);
      queue_query(7 * MM, 7 * MM);
      queue_query(q16_type'(MM + MM / 2), q16_type'(2 * MM + MM / 2));
      queue_query(-MM, 3 * MM);
      queue_query(9 * MM, 9 * MM);
      queue_query(Q16_MIN, Q16_MAX);
      queue_query(Q16_MAX, Q16_MIN);
      // A query right behind a write to one of its corners.
      queue_write(2, 3, draw_height());
      queue_query(2 * MM, 3 * MM);
      wait_idle();

      // Extrapolation past the last cell, and writes to unused register slots.
      write_reg(CSR_EXTRAPOLATE, {31'($urandom), 1'b1});
      for (int i = CSR_EXTRAPOLATE + 1; i < (1 << $bits(csr_idx_type)); i++) begin
         write_reg(csr_idx_type'(i), $urandom);
      end
      queue_query(9 * MM, 9 * MM);
      queue_query(-2 * MM, -MM);
      queue_query(Q16_MAX, Q16_MAX);
      queue_query(Q16_MIN, Q16_MIN);
      queue_query(q16_type'(7 * MM + MM / 2), q16_type'(6 * MM + MM / 4));
      wait_idle();

      // Zero reciprocal spacing on X, largest on Y, origins at the extremes.
      write_reg(CSR_INV_SPACING_X, '0);
      write_reg(CSR_INV_SPACING_Y, {4'hF, INV_MAX});
      write_reg(CSR_ORIGIN_X, Q16_MAX);
      write_reg(CSR_ORIGIN_Y, Q16_MIN);
      queue_query(Q16_MIN, Q16_MAX);
      queue_query($urandom, $urandom);
      queue_query($urandom, $urandom);
      wait_idle();

      stress_go = 1'b1;
      repeat (6) begin
         write_reg(CSR_ORIGIN_X, draw_origin());
         write_reg(CSR_ORIGIN_Y, draw_origin());
         write_reg(CSR_INV_SPACING_X, draw_inv());
         write_reg(CSR_INV_SPACING_Y, draw_inv());
         write_reg(CSR_EXTRAPOLATE, $urandom);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
               queue_write($urandom_range(0, GRID_X - 1), $urandom_range(0, GRID_Y - 1),
                           draw_height());
            end else begin
               queue_query(draw_coord(org_x_cfg, inv_x_cfg, GRID_X),
                           draw_coord(org_y_cfg, inv_y_cfg, GRID_Y));
            end
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("mesh_bilinear_z_offset_tb: clean");
      end else begin
         $display("mesh_bilinear_z_offset_tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/mbzo_pkg.sv
rtl/core/mesh_bilinear_z_offset.sv
tb/mesh_bilinear_z_offset_tb.sv
